// ----- rtl/mrf_pkg.sv -----
package mrf_pkg;

  // request fields as taken on the input side
  typedef struct packed {
    logic [7:0]  device_address;
    logic [15:0] start_register;
    logic [15:0] register_count;
  } req_t;

  // one frame byte as delivered
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } rsp_t;

  localparam int QueueDepthDefault = 2;

  localparam logic [15:0] CrcPreset       = 16'hFFFF;
  localparam logic [15:0] CrcPoly         = 16'hA001;
  localparam logic [7:0]  FuncReadHolding = 8'h03;

  // byte positions within the frame
  localparam logic [2:0] PosAddr     = 3'd0;
  localparam logic [2:0] PosFunc     = 3'd1;
  localparam logic [2:0] PosStartHi  = 3'd2;
  localparam logic [2:0] PosStartLo  = 3'd3;
  localparam logic [2:0] PosCountHi  = 3'd4;
  localparam logic [2:0] PosCountLo  = 3'd5;
  localparam logic [2:0] PosCrcLo    = 3'd6;
  localparam logic [2:0] PosCrcHi    = 3'd7;

  // crc-16/modbus update over one byte, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] acc;
    acc = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ CrcPoly;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

endpackage

// ----- rtl/mrf_front.sv -----
module mrf_front import mrf_pkg::*; #(
  parameter int QueueDepth = QueueDepthDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic q_valid,
  output req_t q_data,
  input  logic q_take
);

  localparam int IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  req_t            mem [QueueDepth];
  logic [IdxW-1:0] head;
  logic [IdxW-1:0] tail;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;

  // accept when the queue has room
  assign busy    = (count == CntW'(QueueDepth));
  assign push    = start && !busy;
  assign q_valid = (count != '0);
  assign pop     = q_take && q_valid;
  assign q_data  = mem[head];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= request;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        if (tail == IdxW'(QueueDepth - 1)) begin
          tail <= '0;
        end else begin
          tail <= tail + 1'b1;
        end
      end
      if (pop) begin
        if (head == IdxW'(QueueDepth - 1)) begin
          head <= '0;
        end else begin
          head <= head + 1'b1;
        end
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/mrf_back.sv -----
module mrf_back import mrf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  req_t q_data,
  output logic q_take,
  output logic strobe,
  output rsp_t result
);

  logic        active;
  logic [2:0]  pos;
  req_t        cur;
  logic [15:0] crc;
  logic [7:0]  byte_sel;
  logic        at_end;

  // take the next request when idle or on the final byte
  assign at_end = active && (pos == PosCrcHi);
  assign q_take = q_valid && (!active || at_end);

  // pick the byte for the current position
  always_comb begin
    case (pos)
      PosAddr:    byte_sel = cur.device_address;
      PosFunc:    byte_sel = FuncReadHolding;
      PosStartHi: byte_sel = cur.start_register[15:8];
      PosStartLo: byte_sel = cur.start_register[7:0];
      PosCountHi: byte_sel = cur.register_count[15:8];
      PosCountLo: byte_sel = cur.register_count[7:0];
      PosCrcLo:   byte_sel = crc[7:0];
      PosCrcHi:   byte_sel = crc[15:8];
      default:    byte_sel = 8'h00;
    endcase
  end

  assign strobe            = active;
  assign result.frame_byte = byte_sel;
  assign result.last_byte  = at_end;

  // control: active flag and byte position
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pos    <= PosAddr;
    end else if (q_take) begin
      active <= 1'b1;
      pos    <= PosAddr;
    end else if (at_end) begin
      active <= 1'b0;
      pos    <= PosAddr;
    end else if (active) begin
      pos <= pos + 1'b1;
    end
  end

  // held request and running crc, one byte per cycle
  always_ff @(posedge clk) begin
    if (q_take) begin
      cur <= q_data;
      crc <= CrcPreset;
    end else if (active && (pos < PosCrcLo)) begin
      crc <= crc_byte(crc, byte_sel);
    end
  end

endmodule

// ----- rtl/modbus_read_request_framer.sv -----
// Modbus RTU read-holding-registers request framer. Each request (device
// address, start register, register count) becomes an 8-byte frame sent one
// byte per cycle on result, each marked by a one-cycle strobe; last_byte
// flags the CRC high byte. The receiver cannot stall: it must take a byte in
// every strobe cycle. An accepted request is written into the queue, and the
// serializer loads it from there when idle or on the final byte of a frame.
// Requests land in a short queue (QueueDepth entries) and busy is high while
// it is full; the byte serializer, which folds one byte a cycle into the
// CRC-16/MODBUS, takes the next queued request on the last byte, so frames go back to back with no gap between them.
module modbus_read_request_framer import mrf_pkg::*; #(
  parameter int QueueDepth = QueueDepthDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic strobe,
  output rsp_t result
);

  logic q_valid;
  req_t q_data;
  logic q_take;

  // request intake and queue
  mrf_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_take  (q_take)
  );

  // frame serializer with crc
  mrf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_take  (q_take),
    .strobe  (strobe),
    .result  (result)
  );

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import mrf_pkg::*;

  localparam int CycleLimit      = 200000;
  localparam int ErrorPrintLimit = 10;
  localparam int TailCycles      = 24;
  localparam int FrameBytes      = 8;
  localparam int RandomRequests  = 430;

  // one pending request, optionally held back until the framer has drained
  typedef struct {
    req_t req;
    bit   drain_first;
  } pending_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t request = '0;
  logic busy;
  logic strobe;
  rsp_t result;

  pending_req_t pending[$];
  rsp_t         frame_bytes_due[$];

  int burst_left = 1;
  int gap_left = 0;
  int requests_sent = 0;
  int bytes_checked = 0;
  int drain_pauses = 0;
  int byte_errors = 0;
  int cycle_count = 0;

  modbus_read_request_framer u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .strobe  (strobe),
    .result  (result)
  );

  always #5 clk = ~clk;

  // full frame for one request, first byte in the top octet
  function automatic logic [63:0] read_request_frame(input req_t r);
    logic [7:0]  msg [6];
    logic [15:0] crc;
    msg[0] = r.device_address;
    msg[1] = FuncReadHolding;
    msg[2] = r.start_register[15:8];
    msg[3] = r.start_register[7:0];
    msg[4] = r.register_count[15:8];
    msg[5] = r.register_count[7:0];
    crc = CrcPreset;
    for (int i = 0; i < 6; i++) begin
      crc[7:0] = crc[7:0] ^ msg[i];
      for (int b = 0; b < 8; b++) begin
        crc = crc[0] ? ((crc >> 1) ^ CrcPoly) : (crc >> 1);
      end
    end
    return {msg[0], msg[1], msg[2], msg[3], msg[4], msg[5], crc[7:0], crc[15:8]};
  endfunction

  // field values leaning toward the extremes now and then
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 125));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic queue_request(input logic [7:0] dev, input logic [15:0] first_reg,
                               input logic [15:0] count, input bit drain);
    pending_req_t p;
    p.req.device_address = dev;
    p.req.start_register = first_reg;
    p.req.register_count = count;
    p.drain_first = drain;
    pending.push_back(p);
  endtask

  // driver: takes accepted requests, predicts their frames, loads the next one
  always @(posedge clk) begin : drive_requests
    logic        next_start;
    logic [63:0] frame;
    rsp_t        due;
    next_start = start;
    if (rst) begin
      next_start = 1'b0;
    end else begin
      if (start && !busy) begin
        frame = read_request_frame(request);
        for (int k = 0; k < FrameBytes; k++) begin
          due.frame_byte = frame[63 - 8 * k -: 8];
          due.last_byte = (k == FrameBytes - 1);
          frame_bytes_due.push_back(due);
        end
        requests_sent++;
        next_start = 1'b0;
      end
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() > 0 &&
                     !(pending[0].drain_first && frame_bytes_due.size() > 0)) begin
          if (pending[0].drain_first) begin
            drain_pauses++;
          end
          request <= pending[0].req;
          pending.pop_front();
          next_start = 1'b1;
          burst_left--;
          // end of burst: pick a gap and the next burst length
          if (burst_left <= 0) begin
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
          end
        end
      end
    end
    start <= next_start;
  end

  // monitor: every strobed byte against the oldest predicted byte
  always @(posedge clk) begin : check_bytes
    rsp_t want;
    if (!rst && strobe) begin
      if (frame_bytes_due.size() == 0) begin
        byte_errors++;
        if (byte_errors <= ErrorPrintLimit) begin
          $display("unexpected frame byte %02h last %0b", result.frame_byte, result.last_byte);
        end
      end else begin
        want = frame_bytes_due.pop_front();
        bytes_checked++;
        if (result.frame_byte !== want.frame_byte || result.last_byte !== want.last_byte) begin
          byte_errors++;
          if (byte_errors <= ErrorPrintLimit) begin
            $display("frame byte mismatch: expected %02h last %0b, got %02h last %0b",
                     want.frame_byte, want.last_byte, result.frame_byte, result.last_byte);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("modbus_read_request_framer regression: fail");
      $finish;
    end
  end

  initial begin
    // directed requests: extremes, a textbook frame, bit patterns
    queue_request(8'h00, 16'h0000, 16'h0000, 1'b0);
    queue_request(8'hFF, 16'hFFFF, 16'hFFFF, 1'b0);
    queue_request(8'h01, 16'h0000, 16'h000A, 1'b0);
    queue_request(8'hFF, 16'h0000, 16'h0000, 1'b0);
    queue_request(8'h00, 16'hFFFF, 16'h0000, 1'b1);
    queue_request(8'h00, 16'h0000, 16'hFFFF, 1'b0);
    queue_request(8'h11, 16'h006B, 16'h0003, 1'b0);
    queue_request(8'hF7, 16'hFF00, 16'h00FF, 1'b0);
    queue_request(8'hAA, 16'hAAAA, 16'h5555, 1'b0);
    queue_request(8'h55, 16'h5555, 16'hAAAA, 1'b0);
    queue_request(8'h80, 16'h8000, 16'h8000, 1'b0);
    queue_request(8'h7F, 16'h7FFF, 16'h7FFF, 1'b0);
    queue_request(8'h01, 16'h0001, 16'h0001, 1'b1);
    queue_request(8'hFE, 16'hFFFE, 16'h007D, 1'b0);
    queue_request(8'h00, 16'h00FF, 16'hFF00, 1'b0);
    queue_request(8'hFF, 16'hFF00, 16'h0001, 1'b0);
    // random requests, with a drain pause now and then
    for (int n = 0; n < RandomRequests; n++) begin
      queue_request(pick_byte(), pick_word(), pick_word(), (n % 97) == 50);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || start) @(posedge clk);
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    $display("sent %0d read requests (%0d after a full drain), checked %0d frame bytes",
             requests_sent, drain_pauses, bytes_checked);
    $display("errors: %0d, bytes still due: %0d", byte_errors, frame_bytes_due.size());
    if (byte_errors == 0 && frame_bytes_due.size() == 0) begin
      $display("modbus_read_request_framer regression: pass");
    end else begin
      $display("modbus_read_request_framer regression: fail");
    end
    $finish;
  end

endmodule
